// ----- src/multi_turn_encoder_tracker_macros.svh -----
// assertion macros for the checker file
`ifndef MULTI_TURN_ENCODER_TRACKER_MACROS_SVH
`define MULTI_TURN_ENCODER_TRACKER_MACROS_SVH

// same-cycle implication
`define MTET_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MTET_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/mtet_pkg.sv -----
package mtet_pkg;

   localparam int ANGLE_W    = 12;
   localparam int POS_W      = 28;
   localparam int TURN_OUT_W = 16;
   localparam int IDX_W      = 5;
   localparam int ACC_W      = 19;
   localparam int UNW_W      = 14;
   localparam int COUNTS     = 4096;
   localparam int HALF_TURN  = 2048;

   localparam logic KIND_TRACK  = 1'b0;
   localparam logic KIND_HOMING = 1'b1;

   typedef logic [ANGLE_W-1:0] angle_type;

   // next homing state and outcome for one sample
   typedef struct packed {
      logic                ref_load;
      logic                done;
      logic [IDX_W-1:0]    index;
      logic [ACC_W-1:0]    acc;
      angle_type           offset;
   } hom_result_type;

endpackage

// ----- src/multi_turn_encoder_tracker.sv -----
// multi-turn tracker for 12-bit absolute encoders, 4096 counts per turn
// req channel: one sample per transfer (kind, channel, raw_angle);
//   kind tracking gives one result, kind homing gives a result only on the
//   last sample of a calibration run (reference plus HOMING_SAMPLES samples)
// rsp channel: position, corrected angle, turn count, homing flag and offset
// path: a sample goes through the input register, then the result register
// throughput: one sample per cycle without rsp stalls, set by the single
//   input register and the single result register; per-channel state is
//   updated as the sample leaves the input register, so back-to-back
//   samples of one channel see it
// reset clears offsets, turn counts, previous angles and any homing run in
//   progress, and empties both registers
// rsp stall: the result register holds its transfer, the input register
//   can still take one more sample, then req_ready drops; samples that give
//   no result drain from the input register even during a stall
module multi_turn_encoder_tracker #(
   parameter int CHANNELS       = 2,
   parameter int HOMING_SAMPLES = 30,
   parameter int TURN_BITS      = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic                                     req_kind,
   input  logic                                     req_channel,
   input  mtet_pkg::angle_type                      req_raw_angle,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic                                     rsp_out_channel,
   output logic signed [mtet_pkg::POS_W-1:0]        rsp_position,
   output mtet_pkg::angle_type                      rsp_corrected_angle,
   output logic signed [mtet_pkg::TURN_OUT_W-1:0]   rsp_turn_count,
   output logic                                     rsp_homing_done,
   output mtet_pkg::angle_type                      rsp_home_offset
);
   import mtet_pkg::*;

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // input register
   logic      s1_valid_ff, s1_valid_in;
   logic      s1_kind_ff;
   logic      s1_channel_ff;
   angle_type s1_angle_ff;

   // per-channel state
   angle_type                   offset_ff [CHANNELS];
   angle_type                   prev_ff   [CHANNELS];
   logic signed [TURN_BITS-1:0] turns_ff  [CHANNELS];
   logic [IDX_W-1:0]            index_ff  [CHANNELS];
   angle_type                   ref_ff    [CHANNELS];
   logic [ACC_W-1:0]            acc_ff    [CHANNELS];

   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_channel_ff, rsp_channel_in;
   logic signed [POS_W-1:0]      rsp_position_ff, rsp_position_in;
   angle_type                    rsp_angle_ff, rsp_angle_in;
   logic signed [TURN_OUT_W-1:0] rsp_turns_ff, rsp_turns_in;
   logic                         rsp_done_ff, rsp_done_in;
   angle_type                    rsp_offset_ff, rsp_offset_in;

   logic [CH_W-1:0]             ch_idx;
   logic                        ch_ok;
   logic                        is_homing;
   hom_result_type              hom;
   angle_type                   trk_angle;
   logic signed [TURN_BITS-1:0] trk_turns;
   logic signed [POS_W-1:0]     trk_position;
   logic signed [TURN_OUT_W-1:0] trk_turn_count;
   logic                        makes_result;
   logic                        out_free;
   logic                        s1_fire;
   logic                        track_we;
   logic                        homing_we;

   assign ch_idx    = CH_W'(s1_channel_ff);
   // channels beyond the configured count are dropped silently
   assign ch_ok     = int'(s1_channel_ff) < CHANNELS;
   assign is_homing = (s1_kind_ff == KIND_HOMING);

   mtet_homing #(
      .HOMING_SAMPLES (HOMING_SAMPLES)
   ) u_homing (
      .raw_angle (s1_angle_ff),
      .ref_angle (ref_ff[ch_idx]),
      .index     (index_ff[ch_idx]),
      .acc       (acc_ff[ch_idx]),
      .result    (hom)
   );

   mtet_track #(
      .TURN_BITS (TURN_BITS)
   ) u_track (
      .raw_angle  (s1_angle_ff),
      .offset     (offset_ff[ch_idx]),
      .prev_angle (prev_ff[ch_idx]),
      .turns      (turns_ff[ch_idx]),
      .angle      (trk_angle),
      .turns_next (trk_turns),
      .position   (trk_position),
      .turn_count (trk_turn_count)
   );

   // handshake: the input register moves on when its result has a place
   assign makes_result = ch_ok && (!is_homing || hom.done);
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign s1_fire      = s1_valid_ff && (!makes_result || out_free);
   assign req_ready    = !s1_valid_ff || s1_fire;
   assign track_we     = s1_fire && ch_ok && !is_homing;
   assign homing_we    = s1_fire && ch_ok && is_homing;

   always_comb begin
      s1_valid_in  = req_ready ? req_valid : s1_valid_ff;
      rsp_valid_in = (s1_fire && makes_result) || (rsp_valid_ff && !rsp_ready);
      rsp_channel_in = s1_channel_ff;
      if (is_homing) begin
         rsp_position_in = '0;
         rsp_angle_in    = '0;
         rsp_turns_in    = '0;
         rsp_done_in     = 1'b1;
         rsp_offset_in   = hom.offset;
      end else begin
         rsp_position_in = trk_position;
         rsp_angle_in    = trk_angle;
         rsp_turns_in    = trk_turn_count;
         rsp_done_in     = 1'b0;
         rsp_offset_in   = offset_ff[ch_idx];
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_kind_ff    <= req_kind;
         s1_channel_ff <= req_channel;
         s1_angle_ff   <= req_raw_angle;
      end
   end

   // per-channel tracking and homing state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            offset_ff[i] <= '0;
            prev_ff[i]   <= '0;
            turns_ff[i]  <= '0;
            index_ff[i]  <= '0;
         end
      end else begin
         if (track_we) begin
            prev_ff[ch_idx]  <= trk_angle;
            turns_ff[ch_idx] <= trk_turns;
         end
         if (homing_we) begin
            index_ff[ch_idx] <= hom.index;
            if (hom.done) begin
               offset_ff[ch_idx] <= hom.offset;
            end
         end
      end
   end

   // homing reference and running sum, overwritten by every reference sample
   always_ff @(posedge clock) begin
      if (homing_we) begin
         acc_ff[ch_idx] <= hom.acc;
         if (hom.ref_load) begin
            ref_ff[ch_idx] <= s1_angle_ff;
         end
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (s1_fire && makes_result) begin
         rsp_channel_ff  <= rsp_channel_in;
         rsp_position_ff <= rsp_position_in;
         rsp_angle_ff    <= rsp_angle_in;
         rsp_turns_ff    <= rsp_turns_in;
         rsp_done_ff     <= rsp_done_in;
         rsp_offset_ff   <= rsp_offset_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_channel     = rsp_channel_ff;
   assign rsp_position        = rsp_position_ff;
   assign rsp_corrected_angle = rsp_angle_ff;
   assign rsp_turn_count      = rsp_turns_ff;
   assign rsp_homing_done     = rsp_done_ff;
   assign rsp_home_offset     = rsp_offset_ff;

endmodule

// ----- src/mtet_homing.sv -----
module mtet_homing #(
   parameter int HOMING_SAMPLES = 30
) (
   input  mtet_pkg::angle_type                raw_angle,
   input  mtet_pkg::angle_type                ref_angle,
   input  logic [mtet_pkg::IDX_W-1:0]         index,
   input  logic [mtet_pkg::ACC_W-1:0]         acc,
   output mtet_pkg::hom_result_type           result
);
   import mtet_pkg::*;

   localparam int LOG_N   = (HOMING_SAMPLES > 1) ? $clog2(HOMING_SAMPLES) : 0;
   localparam int SHIFT   = ACC_W + LOG_N;
   localparam int RECIP_W = ACC_W + 1;
   localparam longint RECIP_L =
      ((longint'(1) <<< SHIFT) + longint'(HOMING_SAMPLES) - 1) / longint'(HOMING_SAMPLES);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
   localparam int PROD_W  = ACC_W + RECIP_W;
   // bias keeps the running sum positive and adds the rounding half
   localparam logic [ACC_W-1:0] BIAS =
      ACC_W'(HOMING_SAMPLES * COUNTS + HOMING_SAMPLES / 2);
   localparam logic [IDX_W-1:0] LAST = IDX_W'(HOMING_SAMPLES);
   localparam logic signed [UNW_W-1:0] HALF_S   = UNW_W'(HALF_TURN);
   localparam logic signed [UNW_W-1:0] COUNTS_S = UNW_W'(COUNTS);

   logic signed [UNW_W-1:0] raw_s;
   logic signed [UNW_W-1:0] ref_s;
   logic signed [UNW_W-1:0] diff;
   logic signed [UNW_W-1:0] unwrapped;
   logic [ACC_W-1:0]        acc_sum;
   logic [PROD_W-1:0]       product;

   assign raw_s = $signed({2'b00, raw_angle});
   assign ref_s = $signed({2'b00, ref_angle});
   assign diff  = raw_s - ref_s;

   always_comb begin
      unwrapped = raw_s;
      if (diff > HALF_S || diff < -HALF_S) begin
         if (raw_angle < ref_angle) begin
            unwrapped = raw_s + COUNTS_S;
         end else begin
            unwrapped = raw_s - COUNTS_S;
         end
      end
   end

   // modular add of a signed term; the true sum stays positive
   assign acc_sum = acc + {{(ACC_W-UNW_W){unwrapped[UNW_W-1]}}, unwrapped};

   // divide by the sample count as multiply by a rounded-up reciprocal
   assign product = PROD_W'(acc_sum) * PROD_W'(RECIP);

   always_comb begin
      result.ref_load = 1'b0;
      result.done     = 1'b0;
      result.index    = index;
      result.acc      = acc_sum;
      result.offset   = product[SHIFT +: ANGLE_W];
      if (index == '0) begin
         result.ref_load = 1'b1;
         result.index    = IDX_W'(1);
         result.acc      = BIAS;
      end else if (index < LAST) begin
         result.index    = index + IDX_W'(1);
      end else begin
         result.done     = 1'b1;
         result.index    = '0;
         result.acc      = BIAS;
      end
   end

endmodule

// ----- src/mtet_track.sv -----
module mtet_track #(
   parameter int TURN_BITS = 16
) (
   input  mtet_pkg::angle_type                      raw_angle,
   input  mtet_pkg::angle_type                      offset,
   input  mtet_pkg::angle_type                      prev_angle,
   input  logic signed [TURN_BITS-1:0]              turns,
   output mtet_pkg::angle_type                      angle,
   output logic signed [TURN_BITS-1:0]              turns_next,
   output logic signed [mtet_pkg::POS_W-1:0]        position,
   output logic signed [mtet_pkg::TURN_OUT_W-1:0]   turn_count
);
   import mtet_pkg::*;

   localparam int EXT_W = (TURN_BITS > TURN_OUT_W) ? TURN_BITS : TURN_OUT_W;
   localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
   localparam logic signed [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};
   localparam logic signed [ANGLE_W:0]     HALF_S   = (ANGLE_W+1)'(HALF_TURN);

   logic signed [ANGLE_W:0] delta;
   logic signed [EXT_W-1:0] turns_ext;

   assign angle = raw_angle - offset;
   assign delta = $signed({1'b0, angle}) - $signed({1'b0, prev_angle});

   // upward jump past half a turn wrapped backward, downward jump forward
   always_comb begin
      turns_next = turns;
      if (delta > HALF_S && turns != TURN_MIN) begin
         turns_next = turns - TURN_BITS'(1);
      end else if (delta < -HALF_S && turns != TURN_MAX) begin
         turns_next = turns + TURN_BITS'(1);
      end
   end

   assign turns_ext  = EXT_W'(turns_next);
   assign turn_count = turns_ext[TURN_OUT_W-1:0];
   assign position   = {turns_ext[POS_W-ANGLE_W-1:0], angle};

endmodule

// ----- src/mtet_checker.sv -----
`include "multi_turn_encoder_tracker_macros.svh"

module mtet_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_kind,
   input logic               req_channel,
   input logic [11:0]        req_raw_angle,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_out_channel,
   input logic signed [27:0] rsp_position,
   input logic [11:0]        rsp_corrected_angle,
   input logic signed [15:0] rsp_turn_count,
   input logic               rsp_homing_done,
   input logic [11:0]        rsp_home_offset
);

   // a stalled result holds
   `MTET_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_position) && $stable(rsp_home_offset) && $stable(rsp_homing_done) && $stable(rsp_out_channel), "stalled result changed")

   // a tracking result is the angle with the turn count above it
   `MTET_ASSERT_NOW(a_track_pos, clock, reset, rsp_valid && !rsp_homing_done, rsp_position[11:0] == rsp_corrected_angle && rsp_position[27:12] == rsp_turn_count, "position does not match angle and turns")

   // a homing result carries no position
   `MTET_ASSERT_NOW(a_homing_zero, clock, reset, rsp_valid && rsp_homing_done, rsp_position == 28'sd0 && rsp_corrected_angle == 12'd0 && rsp_turn_count == 16'sd0, "homing result with nonzero position")

   // a result after an idle output comes from a sample that passed the input register
   `MTET_ASSERT_NOW(a_rsp_origin, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready, 2), "result without a sample")

   // a free output never blocks the input side
   `MTET_ASSERT_NOW(a_ready_flow, clock, reset, rsp_ready, req_ready, "input stalled with output free")

endmodule

bind multi_turn_encoder_tracker mtet_checker u_mtet_checker (.*);

// ----- tb/multi_turn_encoder_tracker_test.sv -----
module multi_turn_encoder_tracker_test;
   import mtet_pkg::*;

   // geometry of the block under test
   localparam int CHANNELS       = 2;
   localparam int HOMING_SAMPLES = 30;
   localparam int TURN_BITS      = 16;

   localparam logic signed [TURN_OUT_W-1:0] TURN_MIN = 16'sh8000;
   localparam logic signed [TURN_OUT_W-1:0] TURN_MAX = 16'sh7fff;

   // run shape
   localparam int RANDOM_ITEMS  = 1050;
   localparam int SWEEP_TURNS   = 20;      // turns swept down, then up past zero
   localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
   localparam int DRAIN_CYCLES  = 10;      // settle time after the last result
   localparam int CYCLE_LIMIT   = 1500000;

   // one sample as the sender will offer it, with its pacing
   typedef struct {
      logic      kind;
      logic      channel;
      angle_type raw;
      int        gap;     // idle cycles after this transfer
      bit        drain;   // offer only once every result is back
      bit        quiet;   // receiver takes results of this stretch without stalls
      bit        hold;    // kick off the long receiver hold-off
   } sample_type;

   // one result as the block should present it
   typedef struct packed {
      logic                           ch;
      logic signed [POS_W-1:0]        pos;
      angle_type                      ang;
      logic signed [TURN_OUT_W-1:0]   turns;
      logic                           done;
      angle_type                      offset;
   } position_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic                            req_kind = KIND_TRACK;
   logic                            req_channel = 1'b0;
   angle_type                       req_raw_angle = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic                            rsp_out_channel;
   logic signed [POS_W-1:0]         rsp_position;
   angle_type                       rsp_corrected_angle;
   logic signed [TURN_OUT_W-1:0]    rsp_turn_count;
   logic                            rsp_homing_done;
   angle_type                       rsp_home_offset;

   multi_turn_encoder_tracker #(
      .CHANNELS       (CHANNELS),
      .HOMING_SAMPLES (HOMING_SAMPLES),
      .TURN_BITS      (TURN_BITS)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_channel         (req_channel),
      .req_raw_angle       (req_raw_angle),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_channel     (rsp_out_channel),
      .rsp_position        (rsp_position),
      .rsp_corrected_angle (rsp_corrected_angle),
      .rsp_turn_count      (rsp_turn_count),
      .rsp_homing_done     (rsp_homing_done),
      .rsp_home_offset     (rsp_home_offset)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // stimulus waiting to be offered, and positions still owed by the block
   sample_type   sample_queue[$];
   position_type pending_positions[$];

   // tracker state mirrored per channel
   angle_type                     home_offset[CHANNELS];
   angle_type                     last_angle[CHANNELS];
   logic signed [TURN_OUT_W-1:0]  turn_total[CHANNELS];
   int                            homing_count[CHANNELS];
   angle_type                     homing_ref[CHANNELS];
   int                            homing_acc[CHANNELS];

   // bookkeeping
   int failures      = 0;
   int samples_sent  = 0;
   int homing_sent   = 0;
   int results_seen  = 0;
   int homing_seen   = 0;
   int limit_seen    = 0;
   int cycle_count   = 0;
   int hold_req      = 0;
   bit rx_quiet      = 1'b0;

   initial begin
      for (int c = 0; c < CHANNELS; c++) begin
         home_offset[c]  = '0;
         last_angle[c]   = '0;
         turn_total[c]   = '0;
         homing_count[c] = 0;
         homing_ref[c]   = '0;
         homing_acc[c]   = 0;
      end
   end

   // expected behavior of one accepted sample; pushes the position it owes
   task automatic track_encoder(input sample_type s);
      position_type want;
      angle_type    ang;
      int           c;
      int           delta;
      int           a;
      int           ref_a;
      int           biased;
      c = int'(s.channel);
      if (s.kind == KIND_TRACK) begin
         // corrected angle wraps naturally at 12 bits
         ang   = s.raw - home_offset[c];
         delta = int'(ang) - int'(last_angle[c]);
         // upward jump past half a turn means we went backward through zero
         if (delta > HALF_TURN && turn_total[c] != TURN_MIN)
            turn_total[c] = turn_total[c] - 16'sd1;
         if (delta < -HALF_TURN && turn_total[c] != TURN_MAX)
            turn_total[c] = turn_total[c] + 16'sd1;
         last_angle[c] = ang;
         a = int'(ang) + int'(turn_total[c]) * COUNTS;
         want.ch     = s.channel;
         want.pos    = a[POS_W-1:0];
         want.ang    = ang;
         want.turns  = turn_total[c];
         want.done   = 1'b0;
         want.offset = home_offset[c];
         pending_positions.push_back(want);
      end else if (homing_count[c] == 0) begin
         // reference sample opens a calibration run
         homing_ref[c]   = s.raw;
         homing_acc[c]   = 0;
         homing_count[c] = 1;
      end else begin
         a     = int'(s.raw);
         ref_a = int'(homing_ref[c]);
         // unwrap against the reference so a run across zero averages right
         if (a - ref_a > HALF_TURN || a - ref_a < -HALF_TURN)
            a = (a < ref_a) ? a + COUNTS : a - COUNTS;
         homing_acc[c] += a;
         if (homing_count[c] < HOMING_SAMPLES) begin
            homing_count[c]++;
         end else begin
            // bias keeps the dividend positive, so division floors; round half up
            biased = homing_acc[c] + HOMING_SAMPLES * COUNTS + HOMING_SAMPLES / 2;
            home_offset[c]  = angle_type'(biased / HOMING_SAMPLES);
            homing_count[c] = 0;
            homing_acc[c]   = 0;
            want.ch     = s.channel;
            want.pos    = '0;
            want.ang    = '0;
            want.turns  = '0;
            want.done   = 1'b1;
            want.offset = home_offset[c];
            pending_positions.push_back(want);
         end
      end
   endtask

   // compare one transfer from the block against the oldest expectation
   task automatic check_position(input position_type got);
      position_type want;
      if (pending_positions.size() == 0) begin
         if (failures < 10)
            $display("unexpected result: ch %0d pos %0d ang %0d turns %0d done %0d off %0d",
                     got.ch, got.pos, got.ang, got.turns, got.done, got.offset);
         failures++;
      end else begin
         want = pending_positions.pop_front();
         if (got.ch !== want.ch || got.pos !== want.pos || got.ang !== want.ang ||
             got.turns !== want.turns || got.done !== want.done ||
             got.offset !== want.offset) begin
            if (failures < 10) begin
               $display("mismatch at result %0d", results_seen);
               $display("  expected ch %0d pos %0d ang %0d turns %0d done %0d off %0d",
                        want.ch, want.pos, want.ang, want.turns, want.done, want.offset);
               $display("  actual   ch %0d pos %0d ang %0d turns %0d done %0d off %0d",
                        got.ch, got.pos, got.ang, got.turns, got.done, got.offset);
            end
            failures++;
         end
      end
   endtask

   // sender: offers queued samples, predicts each one at its transfer
   sample_type cur_sample;
   int         send_gap = 0;

   always @(posedge clock) begin
      sample_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            track_encoder(cur_sample);
            samples_sent++;
            if (cur_sample.kind == KIND_HOMING)
               homing_sent++;
         end
         // a sample still waiting for ready keeps valid and payload as they are
         if (!(req_valid && !req_ready)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (sample_queue.size() != 0 &&
                         (!sample_queue[0].drain || pending_positions.size() == 0)) begin
               nxt = sample_queue.pop_front();
               cur_sample    = nxt;
               req_kind      <= nxt.kind;
               req_channel   <= nxt.channel;
               req_raw_angle <= nxt.raw;
               req_valid     <= 1'b1;
               send_gap      = nxt.gap;
               rx_quiet      <= nxt.quiet;
               if (nxt.hold)
                  hold_req <= hold_req + 1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: checks each transfer, stalls at random, and once holds off long
   int rx_stall  = 0;
   int rx_hold   = 0;
   int hold_seen = 0;

   always @(posedge clock) begin
      position_type got;
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_stall = 0;
         rx_hold  = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.ch     = rsp_out_channel;
            got.pos    = rsp_position;
            got.ang    = rsp_corrected_angle;
            got.turns  = rsp_turn_count;
            got.done   = rsp_homing_done;
            got.offset = rsp_home_offset;
            check_position(got);
            results_seen++;
            if (rsp_homing_done)
               homing_seen++;
            if (rsp_turn_count == TURN_MIN || rsp_turn_count == TURN_MAX)
               limit_seen++;
            rx_stall = rx_quiet ? 0 : $urandom_range(0, 15);
         end
         // the sender asks for a hold-off; the count runs here
         if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            rx_hold   = HOLD_CYCLES;
         end
         if (rx_hold > 0) begin
            rx_hold--;
            rsp_ready <= 1'b0;
         end else if (rx_stall > 0) begin
            rx_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_positions.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic queue_sample(input logic kind, input logic ch, input angle_type raw,
                               input int gap, input bit drain, input bit quiet,
                               input bit hold);
      sample_type s;
      s.kind    = kind;
      s.channel = ch;
      s.raw     = raw;
      s.gap     = gap;
      s.drain   = drain;
      s.quiet   = quiet;
      s.hold    = hold;
      sample_queue.push_back(s);
   endtask

   function automatic int idle_gap(input bit idle_on);
      return idle_on ? int'($urandom_range(0, 15)) : 0;
   endfunction

   initial begin
      int        queued;
      int        episode;
      int        len;
      int        posn;
      int        vel;
      int        mode;
      int        spread;
      bit        idle_on;
      bit        quiet;
      bit        first;
      bit        lead_drain;
      bit        lead_hold;
      logic      ch;
      angle_type ref_raw;
      angle_type pick;
      angle_type smp;

      // directed: wrap thresholds on both channels, extremes of the angle
      queue_sample(KIND_TRACK, 1'b0, 12'd0,    idle_gap(1), 0, 0, 0);
      queue_sample(KIND_TRACK, 1'b0, 12'd4095, idle_gap(1), 0, 0, 0);  // backward wrap
      queue_sample(KIND_TRACK, 1'b0, 12'd0,    idle_gap(1), 0, 0, 0);  // forward wrap
      queue_sample(KIND_TRACK, 1'b0, 12'd2048, idle_gap(1), 0, 0, 0);  // exactly half up
      queue_sample(KIND_TRACK, 1'b0, 12'd0,    idle_gap(1), 0, 0, 0);  // exactly half down
      queue_sample(KIND_TRACK, 1'b0, 12'd2049, idle_gap(1), 0, 0, 0);  // just past half
      queue_sample(KIND_TRACK, 1'b0, 12'd1,    idle_gap(1), 0, 0, 0);
      queue_sample(KIND_TRACK, 1'b0, 12'd0,    idle_gap(1), 0, 0, 0);
      queue_sample(KIND_TRACK, 1'b1, 12'd4095, idle_gap(1), 0, 0, 0);
      queue_sample(KIND_TRACK, 1'b1, 12'd2047, idle_gap(1), 0, 0, 0);
      queue_sample(KIND_TRACK, 1'b1, 12'd4095, idle_gap(1), 0, 0, 0);
      queue_sample(KIND_TRACK, 1'b1, 12'd1,    idle_gap(1), 0, 0, 0);  // forward wrap
      queue_sample(KIND_TRACK, 1'b1, 12'd2050, idle_gap(1), 0, 0, 0);  // backward wrap
      queue_sample(KIND_TRACK, 1'b1, 12'd2050, idle_gap(1), 0, 0, 0);  // no motion

      // sweep channel 0 down through several turns, then up as far again past
      // zero; the sender first waits for the directed results
      for (int i = 0; i < SWEEP_TURNS; i++) begin
         queue_sample(KIND_TRACK, 1'b0, 12'd0,    0, i == 0, 1, 0);
         queue_sample(KIND_TRACK, 1'b0, 12'd2049, 0, 0, 1, 0);   // one turn down
         queue_sample(KIND_TRACK, 1'b0, 12'd1,    0, 0, 1, 0);
      end
      for (int i = 0; i < 2 * SWEEP_TURNS; i++) begin
         queue_sample(KIND_TRACK, 1'b0, 12'd2048, 0, 0, 1, 0);
         queue_sample(KIND_TRACK, 1'b0, 12'd2049, 0, 0, 1, 0);
         queue_sample(KIND_TRACK, 1'b0, 12'd0,    0, 0, 1, 0);   // one turn up
      end

      // random episodes: motion bursts, calibration runs with traffic mixed
      // in, and plain noise
      queued = 0;
      first  = 1'b1;
      while (queued < RANDOM_ITEMS) begin
         episode    = $urandom_range(0, 9);
         idle_on    = first ? 1'b0 : ($urandom_range(0, 3) != 0);
         quiet      = first ? 1'b0 : ($urandom_range(0, 3) == 0);
         lead_drain = !first && ($urandom_range(0, 9) == 0);
         lead_hold  = first;
         ch         = 1'($urandom_range(0, 1));
         if (first || episode < 4) begin
            // steady motion, sometimes fast enough to straddle half a turn
            len  = $urandom_range(5, 40);
            posn = $urandom_range(0, 4095);
            vel  = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1500, 2600))
                                                : int'($urandom_range(0, 300));
            if ($urandom_range(0, 1))
               vel = -vel;
            for (int j = 0; j < len; j++) begin
               if ($urandom_range(0, 15) == 0)
                  posn = $urandom_range(0, 4095);
               else
                  posn = (posn + vel) & (COUNTS - 1);
               queue_sample(KIND_TRACK, ch, angle_type'(posn), idle_gap(idle_on),
                            j == 0 && lead_drain, quiet, j == 0 && lead_hold);
               queued++;
            end
         end else if (episode < 8) begin
            // calibration: jitter around the reference, rounding halves of
            // either sign, an average landing on a full turn, or anything
            mode   = $urandom_range(0, 3);
            pick   = $urandom_range(0, 1) ? 12'd1 : 12'd4095;
            spread = $urandom_range(0, 1) ? 20 : 2100;
            case (mode)
               0: ref_raw = angle_type'($urandom_range(0, 4095));
               1: ref_raw = 12'd0;
               2: ref_raw = 12'd4095;
               default: ref_raw = angle_type'($urandom_range(0, 4095));
            endcase
            queue_sample(KIND_HOMING, ch, ref_raw, idle_gap(idle_on), lead_drain, quiet, 0);
            queued++;
            for (int j = 0; j < HOMING_SAMPLES; j++) begin
               case (mode)
                  0: smp = angle_type'(int'(ref_raw) +
                                       int'($urandom_range(0, 2 * spread)) - spread);
                  1: smp = (j < HOMING_SAMPLES / 2) ? pick : 12'd0;
                  2: smp = 12'd0;
                  default: smp = angle_type'($urandom_range(0, 4095));
               endcase
               queue_sample(KIND_HOMING, ch, smp, idle_gap(idle_on), 0, quiet, 0);
               queued++;
               // tracking carries on during calibration
               if ($urandom_range(0, 3) == 0) begin
                  queue_sample(KIND_TRACK, 1'($urandom_range(0, 1)),
                               angle_type'($urandom_range(0, 4095)),
                               idle_gap(idle_on), 0, quiet, 0);
                  queued++;
               end
               // now and then the other channel's calibration advances too
               if ($urandom_range(0, 19) == 0) begin
                  queue_sample(KIND_HOMING, ~ch, angle_type'($urandom_range(0, 4095)),
                               idle_gap(idle_on), 0, quiet, 0);
                  queued++;
               end
            end
         end else begin
            for (int j = 0; j < 10; j++) begin
               queue_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            angle_type'($urandom_range(0, 4095)), idle_gap(idle_on),
                            j == 0 && lead_drain, quiet, 0);
               queued++;
            end
         end
         first = 1'b0;
      end

      // reset once, then let the sender and receiver run
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (sample_queue.size() != 0 || req_valid || pending_positions.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_positions.size() != 0)
         failures++;

      $display("sent %0d samples (%0d homing), checked %0d results", samples_sent,
               homing_sent, results_seen);
      $display("%0d calibrations completed, %0d results at a turn limit, %0d failures",
               homing_seen, limit_seen, failures);
      if (failures == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ----- multi_turn_encoder_tracker.f -----
+incdir+src
src/mtet_pkg.sv
src/mtet_homing.sv
src/mtet_track.sv
src/multi_turn_encoder_tracker.sv
src/mtet_checker.sv
tb/multi_turn_encoder_tracker_test.sv
